/* hw/rtl/utf8sp_pkg.sv */
package utf8sp_pkg;

  typedef enum logic [1:0] {
    ST_CHAR  = 2'd0,
    ST_ERROR = 2'd1,
    ST_TERM  = 2'd2
  } status_e;

  localparam logic [7:0] MASK_TOP1  = 8'h80;
  localparam logic [7:0] MASK_TOP2  = 8'hC0;
  localparam logic [7:0] MASK_TOP3  = 8'hE0;
  localparam logic [7:0] MASK_TOP4  = 8'hF0;
  localparam logic [7:0] MASK_TOP5  = 8'hF8;
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  typedef struct packed {
    logic [31:0] char_word;
    status_e     status;
    logic        end_of_string;
  } result_t;

endpackage

/* hw/rtl/utf8sp_core.sv */
module utf8sp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output logic                res_valid_o,
  output utf8sp_pkg::result_t res_o
);
  import utf8sp_pkg::*;

  logic [23:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  need_q, need_d;
  logic        skip_q, skip_d;

  logic        raise;
  status_e     raise_st;
  logic [31:0] word;
  logic [2:0]  need_dec;

  always_comb begin
    case (cnt_q)
      2'd1:    word = {16'h0, data_byte_i, held_q[7:0]};
      2'd2:    word = {8'h0, data_byte_i, held_q[15:0]};
      2'd3:    word = {data_byte_i, held_q[23:0]};
      default: word = {8'h0, held_q} | {24'h0, data_byte_i};
    endcase
    need_dec = need_q - 3'd1;
  end

  always_comb begin
    held_d      = held_q;
    cnt_d       = cnt_q;
    need_d      = need_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    raise       = 1'b0;
    raise_st    = ST_ERROR;

    if (skip_q) begin
      if (final_byte_i) begin
        held_d            = '0;
        cnt_d             = '0;
        need_d            = '0;
        skip_d            = 1'b0;
        res_valid_o       = 1'b1;
        res_o.status      = status_e'(need_q[1:0]);
        res_o.end_of_string = 1'b1;
      end
    end else if (need_q == 3'd0) begin
      if (data_byte_i == 8'h00) begin
        raise    = 1'b1;
        raise_st = ST_TERM;
      end else if ((data_byte_i & MASK_TOP1) == 8'h00) begin
        res_valid_o         = 1'b1;
        res_o.char_word     = {24'h0, data_byte_i};
        res_o.status        = ST_CHAR;
        res_o.end_of_string = final_byte_i;
        if (final_byte_i) begin
          held_d = '0;
          cnt_d  = '0;
        end
      end else begin
        if ((data_byte_i & MASK_TOP3) == LEAD_TWO) begin
          need_d = 3'd1;
        end else if ((data_byte_i & MASK_TOP4) == LEAD_THREE) begin
          need_d = 3'd2;
        end else if ((data_byte_i & MASK_TOP5) == LEAD_FOUR) begin
          need_d = 3'd3;
        end else begin
          raise = 1'b1;
        end
        if (final_byte_i) begin
          raise = 1'b1;
        end
        held_d = {16'h0, data_byte_i};
        cnt_d  = 2'd1;
      end
    end else begin
      if ((data_byte_i & MASK_TOP2) != CONT_MARK) begin
        raise = 1'b1;
      end else if (need_dec == 3'd0) begin
        held_d              = '0;
        cnt_d               = '0;
        need_d              = '0;
        res_valid_o         = 1'b1;
        res_o.char_word     = word;
        res_o.status        = ST_CHAR;
        res_o.end_of_string = final_byte_i;
      end else if (final_byte_i) begin
        raise = 1'b1;
      end else begin
        held_d = word[23:0];
        cnt_d  = cnt_q + 2'd1;
        need_d = need_dec;
      end
    end

    if (raise) begin
      held_d = '0;
      cnt_d  = '0;
      if (final_byte_i) begin
        need_d              = '0;
        skip_d              = 1'b0;
        res_valid_o         = 1'b1;
        res_o.char_word     = '0;
        res_o.status        = raise_st;
        res_o.end_of_string = 1'b1;
      end else begin
        need_d = {1'b0, raise_st};
        skip_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
      need_q <= '0;
      skip_q <= 1'b0;
    end else if (step_i) begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
      need_q <= need_d;
      skip_q <= skip_d;
    end
  end

endmodule

/* hw/rtl/utf8_sequence_packer.sv */
// Groups the bytes of UTF-8 strings into one 32-bit word per character.
// Input channel: in_valid_i / in_stall_o with data_byte_i and final_byte_i,
// one byte per item, final_byte_i set on the last byte of each string.
// Output channel: out_valid_o / out_stall_i with char_word_o, status_o and
// end_of_string_o. Every string closes with exactly one item that has
// end_of_string_o set; errors and terminators carry a zero char_word_o.
// An accepted byte lands in an input register and is decoded by the
// sequence logic as that register advances; the result goes to an output
// register. One byte per cycle is taken unless the receiver stalls.
// Bytes that complete no character or close no string give no item.
// When the receiver stalls with a result held, the input register holds
// its byte and in_stall_o rises while that register is occupied.
// Reset clears the open sequence, the drop-to-end flag and both valid bits.
module utf8_sequence_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] char_word_o,
  output logic [1:0]  status_o,
  output logic        end_of_string_o
);
  import utf8sp_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       fin_q;
  logic       advance;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      fin_q  <= final_byte_i;
    end
  end

  utf8sp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (byte_q),
    .final_byte_i (fin_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign char_word_o     = out_q.char_word;
  assign status_o        = out_q.status;
  assign end_of_string_o = out_q.end_of_string;

endmodule
